[rtl/core/pecf_pkg.sv]
// Types, constants and coefficient tables for the pileup energy correction factor.
package pecf_pkg;

	typedef logic [2:0] set_t;
	typedef logic signed [24:0] coef_t;

	localparam logic [16:0] Unity = 17'h10000;
	localparam logic [15:0] RatioMax = 16'hFFFF;
	localparam int DivStages = 4;
	localparam int BitsPerStage = 4;

	localparam set_t Set0 = 3'd0;
	localparam set_t Set1 = 3'd1;
	localparam set_t Set2 = 3'd2;
	localparam set_t Set3 = 3'd3;
	localparam set_t Set4 = 3'd4;
	localparam set_t Set5 = 3'd5;

	typedef struct packed {
		logic valid;
		logic bad;
		logic above;
		logic sat;
		set_t set;
	} ctl_t;

	// Q24 coefficients
	function automatic coef_t coef_const(input set_t s);
		coef_t c;
		case (s)
			Set0: c = 25'sd16708463;
			Set1: c = 25'sd16630248;
			Set2: c = 25'sd16458768;
			Set3: c = 25'sd13221319;
			Set4: c = 25'sd10032037;
			default: c = 25'sd9038406;
		endcase
		return c;
	endfunction

	function automatic coef_t coef_lin(input set_t s);
		coef_t c;
		case (s)
			Set0: c = -25'sd906914;
			Set1: c = -25'sd1750888;
			Set2: c = -25'sd3622805;
			Set3: c = -25'sd2479689;
			Set4: c = -25'sd2698531;
			default: c = -25'sd2589715;
		endcase
		return c;
	endfunction

	function automatic logic [19:0] coef_sq(input set_t s);
		logic [19:0] c;
		case (s)
			Set0: c = 20'd0;
			Set1: c = 20'd0;
			Set2: c = 20'd613897;
			Set3: c = 20'd270559;
			Set4: c = 20'd302079;
			default: c = 20'd309196;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/pileup_energy_correction_factor_top.sv]
// Top level of the pileup energy correction factor pipeline.
//
// Usage: drive tower_index, momentum and energy_difference with start high
// for one cycle per item. busy is always low, so an item may be issued in
// every cycle. Each item gives one result: factor (Q16, 65536 = 1.0),
// correction_applied and bad_momentum, shown for exactly one cycle with done
// high. Results come out in issue order.
// Throughput: one item per cycle.
// Pipeline: one stage for set selection, cut test and saturation check,
// four stages of a restoring divider at four quotient bits each, two
// multiplier stages, one accumulate stage, one rounding/output stage.
// Reset clears all valid bits; items in flight are dropped and done stays
// low until new items arrive. The receiver cannot stall the pipeline.
module pileup_energy_correction_factor_top
	import pecf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [6:0]  tower_index,
	input  logic [15:0]        momentum,
	input  logic signed [15:0] energy_difference,
	output logic               done,
	output logic [16:0]        factor,
	output logic               correction_applied,
	output logic               bad_momentum
);

	assign busy = 1'b0;

	// stage 1: set, cut, saturation
	logic [6:0]         idx_mag;
	set_t               set_c;
	logic signed [23:0] d100;
	logic [17:0]        m3;
	logic               above_lo, above_hi, sat_c;

	always_comb begin
		idx_mag = tower_index[6] ? 7'(-tower_index) : 7'(tower_index);
		set_c = 3'(idx_mag >= 7'd7) + 3'(idx_mag >= 7'd16) + 3'(idx_mag >= 7'd25)
			+ 3'(idx_mag >= 7'd26) + 3'(idx_mag >= 7'd27);
		d100 = 24'(energy_difference) * 24'sd100;
		m3 = 18'(momentum) * 18'd3;
		above_lo = d100 > $signed({6'b0, m3});
		above_hi = $signed({energy_difference[15], energy_difference})
			> $signed({1'b0, momentum});
		sat_c = !energy_difference[15] && ({5'b0, energy_difference[14:4]} >= momentum);
	end

	ctl_t        ctl_s  [1:DivStages+4];
	logic [16:0] rem_s  [1:DivStages+1];
	logic [15:0] quo_s  [1:DivStages+1];
	logic [15:0] mom_s  [1:DivStages+1];
	logic [3:0]  nlo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[1] <= '0;
		end else begin
			ctl_s[1].valid <= start;
			ctl_s[1].bad <= momentum == 16'd0;
			ctl_s[1].above <= (set_c > Set2) ? above_hi : above_lo;
			ctl_s[1].sat <= sat_c;
			ctl_s[1].set <= set_c;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[1] <= {6'b0, energy_difference[14:4]};
		quo_s[1] <= '0;
		mom_s[1] <= momentum;
		nlo_s1 <= energy_difference[3:0];
	end

	// divider stages: four quotient bits each
	for (genvar k = 1; k <= DivStages; k++) begin : g_div
		logic [16:0] rem_c;
		logic [15:0] quo_c;
		logic        bit_in;

		always_comb begin
			rem_c = rem_s[k];
			quo_c = quo_s[k];
			for (int i = 0; i < BitsPerStage; i++) begin
				bit_in = (k == 1) ? nlo_s1[BitsPerStage-1-i] : 1'b0;
				rem_c = {rem_c[15:0], bit_in};
				if (rem_c >= {1'b0, mom_s[k]}) begin
					rem_c = rem_c - {1'b0, mom_s[k]};
					quo_c = {quo_c[14:0], 1'b1};
				end else begin
					quo_c = {quo_c[14:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_c;
			quo_s[k+1] <= quo_c;
			mom_s[k+1] <= mom_s[k];
		end
	end

	// multiply, accumulate
	logic [15:0]        ratio;
	logic [31:0]        rr_s6;
	logic signed [41:0] lin_s6, lin_s7;
	logic [51:0]        sq_s7;
	logic signed [55:0] acc_s8;
	coef_t              c0_c;

	assign ratio = ctl_s[DivStages+1].sat ? RatioMax : quo_s[DivStages+1];
	assign c0_c = coef_const(ctl_s[DivStages+3].set);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[DivStages+2] <= '0;
			ctl_s[DivStages+3] <= '0;
			ctl_s[DivStages+4] <= '0;
		end else begin
			ctl_s[DivStages+2] <= ctl_s[DivStages+1];
			ctl_s[DivStages+3] <= ctl_s[DivStages+2];
			ctl_s[DivStages+4] <= ctl_s[DivStages+3];
		end
	end

	always_ff @(posedge clk) begin
		rr_s6 <= 32'(ratio) * 32'(ratio);
		lin_s6 <= 42'(coef_lin(ctl_s[DivStages+1].set)) * 42'($signed({1'b0, ratio}));
		sq_s7 <= 52'(coef_sq(ctl_s[DivStages+2].set)) * 52'(rr_s6);
		lin_s7 <= lin_s6;
		acc_s8 <= $signed({{7{c0_c[24]}}, c0_c, 24'b0})
			+ $signed({{2{lin_s7[41]}}, lin_s7, 12'b0})
			+ $signed({4'b0, sq_s7});
	end

	// round and output
	ctl_t        ctl_o;
	logic [24:0] rnd;
	logic [16:0] quad;

	assign ctl_o = ctl_s[DivStages+4];

	always_comb begin
		rnd = {1'b0, acc_s8[55:32]} + 25'(acc_s8[31]);
		if (acc_s8[55] || rnd > 25'(Unity)) begin
			quad = '0;
		end else begin
			quad = rnd[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_o.bad) begin
			factor <= '0;
			correction_applied <= 1'b0;
			bad_momentum <= 1'b1;
		end else if (!ctl_o.above) begin
			factor <= Unity;
			correction_applied <= 1'b0;
			bad_momentum <= 1'b0;
		end else begin
			factor <= quad;
			correction_applied <= 1'b1;
			bad_momentum <= 1'b0;
		end
	end

endmodule

[tb/pileup_energy_correction_factor_top_test.sv]
// Self-checking testbench for the pileup energy correction factor pipeline.
module pileup_energy_correction_factor_top_test
	import pecf_pkg::*;
();

	localparam int CycleLimit = 200000;
	localparam int RandomItems = 1350;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [6:0]  tower_index;
	logic [15:0]        momentum;
	logic signed [15:0] energy_difference;
	logic               done;
	logic [16:0]        factor;
	logic               correction_applied;
	logic               bad_momentum;

	int cycle_count = 0;

	class factor_scoreboard;
		typedef struct {
			logic [16:0] fac;
			logic        applied;
			logic        bad;
		} factor_item_t;

		factor_item_t due_q[$];
		int errors = 0;
		int accepted = 0;
		int checked = 0;
		int n_applied = 0;
		int n_bad = 0;

		function longint q24_const(input set_t s);
			case (s)
				Set0: return 16708463;
				Set1: return 16630248;
				Set2: return 16458768;
				Set3: return 13221319;
				Set4: return 10032037;
				default: return 9038406;
			endcase
		endfunction

		function longint q24_lin(input set_t s);
			case (s)
				Set0: return -906914;
				Set1: return -1750888;
				Set2: return -3622805;
				Set3: return -2479689;
				Set4: return -2698531;
				default: return -2589715;
			endcase
		endfunction

		function longint q24_sq(input set_t s);
			case (s)
				Set0: return 0;
				Set1: return 0;
				Set2: return 613897;
				Set3: return 270559;
				Set4: return 302079;
				default: return 309196;
			endcase
		endfunction

		function factor_item_t predict_factor(input logic signed [6:0] idx,
				input logic [15:0] mom, input logic signed [15:0] diff);
			factor_item_t res;
			longint j, m, d, r, acc, rounded;
			int n;
			set_t s;
			bit above;
			j = idx;
			if (j < 0)
				j = -j;
			m = mom;
			d = diff;
			n = 0;
			if (j >= 7) n++;
			if (j >= 16) n++;
			if (j >= 25) n++;
			if (j >= 26) n++;
			if (j >= 27) n++;
			s = set_t'(n);
			res.fac = '0;
			res.applied = 1'b0;
			res.bad = 1'b0;
			if (m == 0) begin
				res.bad = 1'b1;
				return res;
			end
			if (s > Set2)
				above = d > m;
			else
				above = d * 100 > m * 3;
			if (!above) begin
				res.fac = Unity;
				return res;
			end
			res.applied = 1'b1;
			r = (d * 4096) / m;
			if (r > 65535)
				r = 65535;
			if (r < -65536)
				r = -65536;
			acc = q24_const(s) * 16777216 + q24_lin(s) * r * 4096 + q24_sq(s) * r * r;
			if (acc >= 0) begin
				rounded = (acc + (64'sd1 <<< 31)) >>> 32;
				if (rounded <= 65536)
					res.fac = rounded[16:0];
			end
			return res;
		endfunction

		function void note_item(input logic signed [6:0] idx, input logic [15:0] mom,
				input logic signed [15:0] diff);
			due_q.push_back(predict_factor(idx, mom, diff));
			accepted++;
		endfunction

		function void check_result(input logic [16:0] fac, input logic applied,
				input logic bad);
			factor_item_t exp_item;
			if (due_q.size() == 0) begin
				$display("%0t: result with nothing pending, factor %0d", $time, fac);
				errors++;
				return;
			end
			exp_item = due_q.pop_front();
			checked++;
			if (applied) n_applied++;
			if (bad) n_bad++;
			if (fac !== exp_item.fac) begin
				$display("%0t: factor expected %0d actual %0d", $time, exp_item.fac, fac);
				errors++;
			end
			if (applied !== exp_item.applied) begin
				$display("%0t: correction_applied expected %0b actual %0b", $time,
					exp_item.applied, applied);
				errors++;
			end
			if (bad !== exp_item.bad) begin
				$display("%0t: bad_momentum expected %0b actual %0b", $time,
					exp_item.bad, bad);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	factor_scoreboard sb;

	pileup_energy_correction_factor_top u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.tower_index        (tower_index),
		.momentum           (momentum),
		.energy_difference  (energy_difference),
		.done               (done),
		.factor             (factor),
		.correction_applied (correction_applied),
		.bad_momentum       (bad_momentum)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(factor, correction_applied, bad_momentum);
	end

	task automatic send_item(input logic signed [6:0] idx, input logic [15:0] mom,
			input logic signed [15:0] diff);
		start <= 1'b1;
		tower_index <= idx;
		momentum <= mom;
		energy_difference <= diff;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(idx, mom, diff);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		logic signed [6:0] idx;
		logic [15:0] mom;
		int diff;
		int mode;
		int j;
		int ratio;
		mode = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			idx = 7'($urandom());
		else
			idx = 7'($urandom_range(0, 82) - 41);
		j = idx;
		if (j < 0)
			j = -j;
		if (mode < 5) begin
			mom = '0;
			diff = $urandom_range(0, 65535) - 32768;
		end else if (mode < 30) begin
			mom = 16'($urandom());
			diff = $urandom_range(0, 65535) - 32768;
		end else if (mode < 45) begin
			// around the cut
			mom = 16'($urandom_range(1, 30000));
			if (j >= 25)
				diff = mom + $urandom_range(0, 2) - 1;
			else
				diff = (3 * mom) / 100 + $urandom_range(0, 2) - 1;
		end else begin
			// ratio between about -0.25 and 2.0
			mom = 16'($urandom_range(1, 4000));
			ratio = $urandom_range(0, 9216) - 1024;
			diff = (int'(mom) * ratio) / 4096;
		end
		if (diff > 32767)
			diff = 32767;
		if (diff < -32768)
			diff = -32768;
		send_item(idx, mom, 16'(diff));
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		tower_index <= '0;
		momentum <= '0;
		energy_difference <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_item(0, 0, 0);
		send_item(-64, 0, 32767);
		send_item(3, 100, 3);
		send_item(3, 100, 4);
		send_item(10, 100, 4);
		send_item(20, 100, 4);
		send_item(-25, 100, 101);
		send_item(25, 100, 100);
		send_item(26, 256, 400);
		send_item(27, 256, 400);
		send_item(41, 1, 32767);
		send_item(-41, 65535, 32767);
		send_item(0, 1, 32767);
		send_item(6, 65535, -32768);
		send_item(7, 1, -32768);
		send_item(15, 1000, 1000);
		idle_cycles(3);
		send_item(16, 1000, 500);
		send_item(24, 4096, 8192);
		send_item(63, 300, 600);
		send_item(-7, 65535, 32767);
		send_item(-16, 2000, 60);
		send_item(-26, 5000, 5001);
		send_item(-27, 1, 2);
		drain_results();

		for (int i = 0; i < RandomItems; i++) begin
			if (i == 900)
				drain_results();
			if ((i < 300 || i > 650) && $urandom_range(0, 99) < 6)
				idle_cycles($urandom_range(1, 4));
			send_random_item();
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d results for %0d items: %0d with correction, %0d zero momentum.",
			sb.checked, sb.accepted, sb.n_applied, sb.n_bad);
		$display("Covered all six tower sets, cut edges, ratio saturation and idle gaps.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/pecf_pkg.sv
rtl/core/pileup_energy_correction_factor_top.sv
tb/pileup_energy_correction_factor_top_test.sv
